/* rtl/rfb_pkg.sv */
`timescale 1ns / 1ps

package rfb_pkg;

    localparam int SLOT_COUNT_DEF = 1024;

    localparam int CFG_W  = 11;
    localparam int SEQ_W  = 16;
    localparam int TS_W   = 32;
    localparam int SRC_W  = 32;
    localparam int POS_W  = 10;
    localparam int SLOT_W = 2 + SEQ_W + TS_W;

    localparam logic [CFG_W-1:0] MAX_FRAME_RST = 11'd200;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUSH_CHK,
        ST_SRC_CLR,
        ST_FULL_FREE,
        ST_HEAD_RD,
        ST_HEAD_EV,
        ST_ERR_CLR,
        ST_POP_START,
        ST_POP_SCAN,
        ST_POP_FREE,
        ST_OUT
    } rfb_state_t;

    typedef struct packed {
        logic load_in;
        logic premark;
        logic src_take;
        logic full_flag;
        logic sweep_all_start;
        logic sweep_head_start;
        logic sweep_step;
        logic sweep_end_clear;
        logic sweep_end_free;
        logic push_eval;
        logic err_flag;
        logic scan_start;
        logic scan_step;
        logic out_load;
    } rfb_cmd_t;

    typedef struct packed {
        logic marker_seen;
        logic src_differs;
        logic table_full;
        logic last_all;
        logic last_free;
        logic last_pop;
        logic pos_bad;
        logic fill_empty;
        logic scan_found;
        logic too_large;
        logic scan_end;
        logic out_free;
    } rfb_status_t;

endpackage

/* rtl/rtp_frame_reorder_buffer.sv */
`timescale 1ns / 1ps

// Channel  Signals                                            Moves
// -------  -------------------------------------------------  --------------------------
// in       in_valid, in_ready, opcode .. timestamp            push or pop request
// out      out_valid, out_ready, op_done .. frame_timestamp   one result per request
// cfg      cfg_valid, cfg_ready, cfg_data                     max_frame_packets write
//
// After reset the slot memory is swept clear before in_ready rises.
// A push clears the whole table when the source changes or the offset falls outside the
// window, and frees the oldest SLOT_COUNT/10 slots (at least one) when the table is full.
// A pop reads one slot a cycle through the single read port, up to the fill level or the
// first complete frame, then frees the slots from the head to its end one a cycle.
// One request is worked on at a time; the next is taken while a result awaits out_ready.

module rtp_frame_reorder_buffer #(
    parameter int SLOT_COUNT = rfb_pkg::SLOT_COUNT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       opcode,
    input  logic [rfb_pkg::SEQ_W-1:0]  seq_number,
    input  logic                       marker,
    input  logic [rfb_pkg::SRC_W-1:0]  stream_source,
    input  logic [rfb_pkg::TS_W-1:0]   timestamp,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       op_done,
    output logic                       dropped,
    output logic                       ssrc_changed,
    output logic                       check_frame,
    output logic                       push_error,
    output logic [rfb_pkg::POS_W-1:0]  slot_position,
    output logic                       frame_found,
    output logic                       frame_too_large,
    output logic [rfb_pkg::POS_W-1:0]  frame_begin,
    output logic [rfb_pkg::POS_W-1:0]  frame_end,
    output logic                       discontinuity,
    output logic [rfb_pkg::TS_W-1:0]   frame_timestamp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [rfb_pkg::CFG_W-1:0]  cfg_data
);

    import rfb_pkg::*;

    rfb_cmd_t    cmd;
    rfb_status_t sts;

    assign cfg_ready = 1'b1;

    rfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_opcode (opcode),
        .in_ready  (in_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rfb_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .opcode          (opcode),
        .seq_number      (seq_number),
        .marker          (marker),
        .stream_source   (stream_source),
        .timestamp       (timestamp),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .op_done         (op_done),
        .dropped         (dropped),
        .ssrc_changed    (ssrc_changed),
        .check_frame     (check_frame),
        .push_error      (push_error),
        .slot_position   (slot_position),
        .frame_found     (frame_found),
        .frame_too_large (frame_too_large),
        .frame_begin     (frame_begin),
        .frame_end       (frame_end),
        .discontinuity   (discontinuity),
        .frame_timestamp (frame_timestamp)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while another is in progress");

    a_pop_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && op_done == OP_POP) |->
            (!dropped && !ssrc_changed && !check_frame && !push_error && slot_position == '0))
        else $error("pop result carries push fields");

    a_push_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && op_done == OP_PUSH) |->
            (!frame_found && !frame_too_large && !discontinuity && frame_begin == '0))
        else $error("push result carries pop fields");

    a_too_large_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_too_large) |-> (frame_found && frame_timestamp == '0))
        else $error("oversize frame reported inconsistently");

endmodule

/* rtl/rfb_ram.sv */
`timescale 1ns / 1ps

module rfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rfb_ctrl.sv */
`timescale 1ns / 1ps

module rfb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_opcode,
    output logic                in_ready,
    input  rfb_pkg::rfb_status_t sts,
    output rfb_pkg::rfb_cmd_t    cmd
);

    import rfb_pkg::*;

    rfb_state_t state_reg;
    rfb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (sts.last_all)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = (in_opcode == OP_POP) ? ST_POP_START : ST_PUSH_CHK;
            end
            ST_PUSH_CHK:
            begin
                if (!sts.marker_seen)
                    state_next = ST_OUT;
                else if (sts.src_differs)
                    state_next = ST_SRC_CLR;
                else if (sts.table_full)
                    state_next = ST_FULL_FREE;
                else
                    state_next = ST_HEAD_RD;
            end
            ST_SRC_CLR:
            begin
                if (sts.last_all)
                    state_next = ST_HEAD_RD;
            end
            ST_FULL_FREE:
            begin
                if (sts.last_free)
                    state_next = ST_HEAD_RD;
            end
            ST_HEAD_RD:
            begin
                state_next = ST_HEAD_EV;
            end
            ST_HEAD_EV:
            begin
                state_next = sts.pos_bad ? ST_ERR_CLR : ST_OUT;
            end
            ST_ERR_CLR:
            begin
                if (sts.last_all)
                    state_next = ST_OUT;
            end
            ST_POP_START:
            begin
                state_next = sts.fill_empty ? ST_OUT : ST_POP_SCAN;
            end
            ST_POP_SCAN:
            begin
                if (sts.scan_found)
                    state_next = sts.too_large ? ST_OUT : ST_POP_FREE;
                else if (sts.scan_end)
                    state_next = ST_OUT;
            end
            ST_POP_FREE:
            begin
                if (sts.last_pop)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_step      = 1'b1;
                cmd.sweep_end_clear = sts.last_all;
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_PUSH_CHK:
            begin
                if (!sts.marker_seen)
                begin
                    cmd.premark = 1'b1;
                end
                else
                begin
                    cmd.src_take = 1'b1;
                    if (sts.src_differs)
                    begin
                        cmd.sweep_all_start = 1'b1;
                    end
                    else if (sts.table_full)
                    begin
                        cmd.full_flag        = 1'b1;
                        cmd.sweep_head_start = 1'b1;
                    end
                end
            end
            ST_SRC_CLR, ST_ERR_CLR:
            begin
                cmd.sweep_step      = 1'b1;
                cmd.sweep_end_clear = sts.last_all;
            end
            ST_FULL_FREE:
            begin
                cmd.sweep_step     = 1'b1;
                cmd.sweep_end_free = sts.last_free;
            end
            ST_HEAD_RD:
            begin
                cmd = '0;
            end
            ST_HEAD_EV:
            begin
                if (sts.pos_bad)
                begin
                    cmd.err_flag        = 1'b1;
                    cmd.sweep_all_start = 1'b1;
                end
                else
                begin
                    cmd.push_eval = 1'b1;
                end
            end
            ST_POP_START:
            begin
                cmd.scan_start = !sts.fill_empty;
            end
            ST_POP_SCAN:
            begin
                cmd.scan_step        = 1'b1;
                cmd.sweep_head_start = sts.scan_found && !sts.too_large;
            end
            ST_POP_FREE:
            begin
                cmd.sweep_step     = 1'b1;
                cmd.sweep_end_free = sts.last_pop;
            end
            ST_OUT:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/rfb_dp.sv */
`timescale 1ns / 1ps

module rfb_dp #(
    parameter int SLOT_COUNT = rfb_pkg::SLOT_COUNT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rfb_pkg::rfb_cmd_t          cmd,
    output rfb_pkg::rfb_status_t       sts,
    input  logic                       opcode,
    input  logic [rfb_pkg::SEQ_W-1:0]  seq_number,
    input  logic                       marker,
    input  logic [rfb_pkg::SRC_W-1:0]  stream_source,
    input  logic [rfb_pkg::TS_W-1:0]   timestamp,
    input  logic                       cfg_valid,
    input  logic [rfb_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic                       op_done,
    output logic                       dropped,
    output logic                       ssrc_changed,
    output logic                       check_frame,
    output logic                       push_error,
    output logic [rfb_pkg::POS_W-1:0]  slot_position,
    output logic                       frame_found,
    output logic                       frame_too_large,
    output logic [rfb_pkg::POS_W-1:0]  frame_begin,
    output logic [rfb_pkg::POS_W-1:0]  frame_end,
    output logic                       discontinuity,
    output logic [rfb_pkg::TS_W-1:0]   frame_timestamp
);

    import rfb_pkg::*;

    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int LEN_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int FREE_N = (SLOT_COUNT > 10) ? SLOT_COUNT / 10 : 1;

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W:0]   off);
        logic [IDX_W+1:0] s;
        s = {2'b00, base} + {1'b0, off};
        if (s >= (IDX_W+2)'(SLOT_COUNT))
            s = s - (IDX_W+2)'(SLOT_COUNT);
        return s[IDX_W-1:0];
    endfunction

    // Request held while it is worked on.
    logic              mk_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [SRC_W-1:0]  src_reg;
    logic [TS_W-1:0]   ts_reg;

    // Table bookkeeping.
    logic [IDX_W-1:0]  head_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [SRC_W-1:0]  srcid_reg;
    logic              loss_reg;
    logic              mseen_reg;
    logic [CFG_W-1:0]  max_reg;

    logic [IDX_W-1:0]  ptr_reg;
    logic [IDX_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  scan_reg;
    logic [CNT_W-1:0]  rb_reg;
    logic              lost_reg;
    logic [TS_W-1:0]   run_ts_reg;
    logic [IDX_W-1:0]  e_reg;

    // Result under construction.
    logic              res_op_reg;
    logic              res_drop_reg;
    logic              res_ssrc_reg;
    logic              res_check_reg;
    logic              res_err_reg;
    logic [POS_W-1:0]  res_pos_reg;
    logic              res_found_reg;
    logic              res_tl_reg;
    logic [POS_W-1:0]  res_begin_reg;
    logic [POS_W-1:0]  res_end_reg;
    logic              res_disc_reg;
    logic [TS_W-1:0]   res_ts_reg;

    // Output stage.
    logic              out_valid_reg;
    logic              o_op_reg;
    logic              o_drop_reg;
    logic              o_ssrc_reg;
    logic              o_check_reg;
    logic              o_err_reg;
    logic [POS_W-1:0]  o_pos_reg;
    logic              o_found_reg;
    logic              o_tl_reg;
    logic [POS_W-1:0]  o_begin_reg;
    logic [POS_W-1:0]  o_end_reg;
    logic              o_disc_reg;
    logic [TS_W-1:0]   o_ts_reg;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [SLOT_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [SLOT_W-1:0] ram_rdata;

    logic              rd_valid;
    logic              rd_marker;
    logic [SEQ_W-1:0]  rd_seq;
    logic [TS_W-1:0]   rd_ts;

    logic [SEQ_W-1:0]  pos_raw;
    logic [IDX_W-1:0]  pos;
    logic [CNT_W-1:0]  pos_ext;
    logic [IDX_W-1:0]  push_phys;
    logic              push_check;
    logic              differs;

    logic [IDX_W-1:0]  scan_phys_next;
    logic              found;
    logic              at_run_begin;
    logic [LEN_W-1:0]  run_len;
    logic              too_large;
    logic [TS_W-1:0]   cur_ts;
    logic [IDX_W-1:0]  ptr_next;

    assign rd_valid  = ram_rdata[SLOT_W-1];
    assign rd_marker = ram_rdata[SLOT_W-2];
    assign rd_seq    = ram_rdata[TS_W +: SEQ_W];
    assign rd_ts     = ram_rdata[TS_W-1:0];

    // An empty head slot puts every packet at offset zero.
    assign pos_raw    = rd_valid ? (seq_reg - rd_seq) : '0;
    assign pos        = pos_raw[IDX_W-1:0];
    assign pos_ext    = CNT_W'(pos);
    assign push_phys  = wrap_add(head_reg, (IDX_W+1)'(pos));
    assign push_check = mk_reg || ((pos_ext < fill_reg) && (pos_ext != fill_reg - 1'b1));
    assign differs    = (srcid_reg != '0) && (src_reg != srcid_reg);

    assign scan_phys_next = wrap_add(head_reg, (IDX_W+1)'(scan_reg) + 1'b1);
    assign found          = rd_valid && rd_marker && !lost_reg;
    assign at_run_begin   = (CNT_W'(scan_reg) == rb_reg);
    assign run_len        = LEN_W'(scan_reg) - LEN_W'(rb_reg) + 1'b1;
    assign too_large      = run_len > LEN_W'(max_reg);
    assign cur_ts         = at_run_begin ? rd_ts : run_ts_reg;
    assign ptr_next       = (ptr_reg == IDX_W'(SLOT_COUNT - 1)) ? '0 : ptr_reg + 1'b1;

    assign ram_we    = cmd.sweep_step || cmd.push_eval;
    assign ram_waddr = cmd.sweep_step ? ptr_reg : push_phys;
    assign ram_wdata = cmd.sweep_step ? '0 : {1'b1, mk_reg, seq_reg, ts_reg};
    assign ram_raddr = cmd.scan_step ? scan_phys_next : head_reg;

    rfb_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        sts.marker_seen = mseen_reg;
        sts.src_differs = differs;
        sts.table_full  = (fill_reg == CNT_W'(SLOT_COUNT));
        sts.last_all    = (cnt_reg == IDX_W'(SLOT_COUNT - 1));
        sts.last_free   = (cnt_reg == IDX_W'(FREE_N - 1));
        sts.last_pop    = (cnt_reg == e_reg);
        sts.pos_bad     = (pos_raw >= SEQ_W'(SLOT_COUNT));
        sts.fill_empty  = (fill_reg == '0);
        sts.scan_found  = found;
        sts.too_large   = too_large;
        sts.scan_end    = ((CNT_W'(scan_reg) + 1'b1) == fill_reg);
        sts.out_free    = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            fill_reg      <= '0;
            srcid_reg     <= '0;
            loss_reg      <= 1'b1;
            mseen_reg     <= 1'b0;
            max_reg       <= MAX_FRAME_RST;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            scan_reg      <= '0;
            rb_reg        <= '0;
            lost_reg      <= 1'b0;
            e_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                max_reg <= cfg_data;

            if (cmd.premark && mk_reg)
                mseen_reg <= 1'b1;

            if (cmd.src_take)
            begin
                if (srcid_reg == '0 || differs)
                    srcid_reg <= src_reg;
                if (differs)
                begin
                    loss_reg  <= 1'b1;
                    mseen_reg <= 1'b1;
                end
            end

            if (cmd.full_flag)
                loss_reg <= 1'b1;

            if (cmd.err_flag)
            begin
                loss_reg  <= 1'b1;
                mseen_reg <= 1'b0;
            end

            if (cmd.sweep_all_start)
            begin
                ptr_reg <= '0;
                cnt_reg <= '0;
            end
            else if (cmd.sweep_head_start)
            begin
                ptr_reg <= head_reg;
                cnt_reg <= '0;
            end
            else if (cmd.sweep_step)
            begin
                ptr_reg <= ptr_next;
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (cmd.sweep_end_clear)
            begin
                head_reg <= '0;
                fill_reg <= '0;
            end
            else if (cmd.sweep_end_free)
            begin
                head_reg <= ptr_next;
                fill_reg <= fill_reg - (CNT_W'(cnt_reg) + 1'b1);
            end
            else if (cmd.push_eval && (pos_ext >= fill_reg))
            begin
                fill_reg <= pos_ext + 1'b1;
            end

            if (cmd.scan_start)
            begin
                scan_reg <= '0;
                rb_reg   <= '0;
                lost_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                scan_reg <= scan_reg + 1'b1;
                e_reg    <= scan_reg;
                if (!rd_valid)
                begin
                    lost_reg <= 1'b1;
                end
                else if (rd_marker && lost_reg)
                begin
                    rb_reg   <= CNT_W'(scan_reg) + 1'b1;
                    lost_reg <= 1'b0;
                end
                if (found && !too_large)
                    loss_reg <= 1'b0;
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mk_reg        <= marker;
            seq_reg       <= seq_number;
            src_reg       <= stream_source;
            ts_reg        <= timestamp;
            res_op_reg    <= opcode;
            res_drop_reg  <= 1'b0;
            res_ssrc_reg  <= 1'b0;
            res_check_reg <= 1'b0;
            res_err_reg   <= 1'b0;
            res_pos_reg   <= '0;
            res_found_reg <= 1'b0;
            res_tl_reg    <= 1'b0;
            res_begin_reg <= '0;
            res_end_reg   <= '0;
            res_disc_reg  <= 1'b0;
            res_ts_reg    <= '0;
        end

        if (cmd.premark)
            res_drop_reg <= 1'b1;
        if (cmd.src_take && differs)
            res_ssrc_reg <= 1'b1;
        if (cmd.full_flag)
            res_drop_reg <= 1'b1;
        if (cmd.err_flag)
        begin
            // An offset outside the window reports the error alone.
            res_drop_reg <= 1'b0;
            res_ssrc_reg <= 1'b0;
            res_err_reg  <= 1'b1;
        end
        if (cmd.push_eval)
        begin
            res_check_reg <= push_check;
            res_pos_reg   <= POS_W'(pos);
        end

        if (cmd.scan_step)
        begin
            if (at_run_begin)
                run_ts_reg <= rd_ts;
            if (found)
            begin
                res_found_reg <= 1'b1;
                res_tl_reg    <= too_large;
                res_begin_reg <= POS_W'(rb_reg);
                res_end_reg   <= POS_W'(scan_reg);
                if (!too_large)
                begin
                    res_disc_reg <= (rb_reg != '0) || loss_reg;
                    res_ts_reg   <= cur_ts;
                end
            end
        end

        if (cmd.out_load)
        begin
            o_op_reg    <= res_op_reg;
            o_drop_reg  <= res_drop_reg;
            o_ssrc_reg  <= res_ssrc_reg;
            o_check_reg <= res_check_reg;
            o_err_reg   <= res_err_reg;
            o_pos_reg   <= res_pos_reg;
            o_found_reg <= res_found_reg;
            o_tl_reg    <= res_tl_reg;
            o_begin_reg <= res_begin_reg;
            o_end_reg   <= res_end_reg;
            o_disc_reg  <= res_disc_reg;
            o_ts_reg    <= res_ts_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign op_done         = o_op_reg;
    assign dropped         = o_drop_reg;
    assign ssrc_changed    = o_ssrc_reg;
    assign check_frame     = o_check_reg;
    assign push_error      = o_err_reg;
    assign slot_position   = o_pos_reg;
    assign frame_found     = o_found_reg;
    assign frame_too_large = o_tl_reg;
    assign frame_begin     = o_begin_reg;
    assign frame_end       = o_end_reg;
    assign discontinuity   = o_disc_reg;
    assign frame_timestamp = o_ts_reg;

endmodule
